// ===== hdl/obns_pkg.sv =====
// ----------------------------------------------------------------------------
// obns_pkg: shared types and constants for the octave noise smoother
// Field widths, register indexes, datapath select codes and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package obns_pkg;

  // Parameter defaults
  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLS_DEF    = 64;
  localparam int MAX_OCTAVES_DEF = 6;

  // Port field widths
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int SMP_W     = 16;
  localparam int VAL_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Register widths
  localparam int DIM_W  = 7;   // rows/cols in use, also wrapped coordinates
  localparam int OCT_W  = 3;
  localparam int PERS_W = 16;

  // Arithmetic widths
  localparam int AMP_W   = 17; // Q1.16 amplitude, up to 1.0
  localparam int NEAR_W  = 22; // one interpolated row
  localparam int MUL_A_W = 28; // holds the full interpolation
  localparam int MUL_B_W = 18;
  localparam int MAC_W   = MUL_A_W + MUL_B_W;
  localparam int TOT_W   = 22;
  localparam int SH_W    = 5;

  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);

  localparam logic signed [VAL_W-1:0] VAL_MAX = 20'sd524287;
  localparam logic signed [VAL_W-1:0] VAL_MIN = -20'sd524288;
  localparam logic signed [TOT_W-1:0] TOT_MAX = 22'sd524287;
  localparam logic signed [TOT_W-1:0] TOT_MIN = -22'sd524288;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERS  = 2'd3;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Read coordinate select
  localparam int RSEL_W = 3;
  localparam logic [RSEL_W-1:0] RS_CENTER = 3'd0;
  localparam logic [RSEL_W-1:0] RS_C00    = 3'd1;
  localparam logic [RSEL_W-1:0] RS_C01    = 3'd2;
  localparam logic [RSEL_W-1:0] RS_C10    = 3'd3;
  localparam logic [RSEL_W-1:0] RS_C11    = 3'd4;

  // Multiplier operand select
  localparam int MSEL_W = 3;
  localparam logic [MSEL_W-1:0] MS_CORNER_WX0 = 3'd0;
  localparam logic [MSEL_W-1:0] MS_CORNER_WX1 = 3'd1;
  localparam logic [MSEL_W-1:0] MS_NEAR_WY0   = 3'd2;
  localparam logic [MSEL_W-1:0] MS_FAR_WY1    = 3'd3;
  localparam logic [MSEL_W-1:0] MS_MAC_AMP    = 3'd4;
  localparam logic [MSEL_W-1:0] MS_AMP_PERS   = 3'd5;

  typedef struct packed {
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [OCT_W-1:0]  octs;
    logic [PERS_W-1:0] pers;
  } cfg_t;

  typedef struct packed {
    logic              latch_in;
    logic              ram_we;
    logic              rd_en;
    logic [RSEL_W-1:0] rsel;
    logic [MSEL_W-1:0] msel;
    logic              mac_en;
    logic              mac_load;
    logic              near_en;
    logic              far_en;
    logic              amp_init;
    logic              amp_en;
    logic              div_start;
    logic              tot_init;
    logic              tot_add;
    logic              oct_inc;
    logic              out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic noct_zero;
    logic last_oct;
  } dp_stat_t;

endpackage

// ===== hdl/obns_ram.sv =====
// ----------------------------------------------------------------------------
// obns_ram: generic single-clock RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module obns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/obns_mod.sv =====
// ----------------------------------------------------------------------------
// obns_mod: two-lane iterative remainder unit
// Restoring division, one bit per cycle; yields (a mod n) for row and column.
// ----------------------------------------------------------------------------
module obns_mod (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [1:0][obns_pkg::DIM_W-1:0]  dividend,
  input  logic [1:0][obns_pkg::DIM_W-1:0]  divisor,
  output logic [1:0][obns_pkg::DIM_W-1:0]  remainder,
  output logic                             busy
);
  import obns_pkg::*;

  localparam int CNT_W = $clog2(DIM_W);

  logic                         busy_r, busy_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [1:0][DIM_W-1:0]        rem_r, rem_nxt;
  logic [1:0][DIM_W-1:0]        quo_r, quo_nxt;
  logic [1:0][DIM_W-1:0]        den_r, den_nxt;
  logic [1:0][DIM_W:0]          trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_r[l], quo_r[l][DIM_W-1]};
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIM_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      for (int l = 0; l < 2; l++) begin
        // remainder stays below the divisor, so the trial fits DIM_W+1 bits
        if (trial[l] >= {1'b0, den_r[l]}) begin
          rem_nxt[l] = DIM_W'(trial[l] - {1'b0, den_r[l]});
        end else begin
          rem_nxt[l] = trial[l][DIM_W-1:0];
        end
        quo_nxt[l] = {quo_r[l][DIM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign remainder = rem_r;
  assign busy      = busy_r;

endmodule

// ===== hdl/obns_dp.sv =====
// ----------------------------------------------------------------------------
// obns_dp: datapath of the octave noise smoother
// Grid RAM, coordinate and weight logic, shared multiply-accumulate,
// amplitude register, rounding accumulator and output register.
// ----------------------------------------------------------------------------
module obns_dp #(
  parameter int MAX_ROWS    = obns_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = obns_pkg::MAX_COLS_DEF,
  parameter int MAX_OCTAVES = obns_pkg::MAX_OCTAVES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  obns_pkg::dp_cmd_t                 cmd,
  output obns_pkg::dp_stat_t                stat,
  input  obns_pkg::cfg_t                    cfg,
  input  logic [obns_pkg::ROW_W-1:0]        in_row,
  input  logic [obns_pkg::COL_W-1:0]        in_col,
  input  logic signed [obns_pkg::SMP_W-1:0] in_sample,
  output logic signed [obns_pkg::VAL_W-1:0] out_value,
  output logic                              out_saturated
);
  import obns_pkg::*;

  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int AW      = $clog2(DEPTH);
  localparam int ROW_CAP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
  localparam int COL_CAP = (MAX_COLS > 127) ? 127 : MAX_COLS;
  localparam int OCT_CAP = (MAX_OCTAVES > 7) ? 7 : MAX_OCTAVES;

  // latched item
  logic [ROW_W-1:0]        row_r;
  logic [COL_W-1:0]        col_r;
  logic signed [SMP_W-1:0] smp_r;

  logic [OCT_W-1:0]         oct_r;
  logic [AMP_W-1:0]         amp_r, amp_nxt;
  logic signed [MAC_W-1:0]  mac_r, mac_nxt;
  logic signed [NEAR_W-1:0] near_r, far_r;
  logic signed [TOT_W-1:0]  tot_r, tot_nxt;
  logic                     rd_oob_r;
  logic signed [VAL_W-1:0]  val_r;
  logic                     sat_r;

  // effective configuration
  logic [DIM_W-1:0] nr, nc;
  logic [OCT_W-1:0] noct;

  always_comb begin
    if (cfg.rows == '0) begin
      nr = DIM_W'(1);
    end else if (cfg.rows > DIM_W'(ROW_CAP)) begin
      nr = DIM_W'(ROW_CAP);
    end else begin
      nr = cfg.rows;
    end
    if (cfg.cols == '0) begin
      nc = DIM_W'(1);
    end else if (cfg.cols > DIM_W'(COL_CAP)) begin
      nc = DIM_W'(COL_CAP);
    end else begin
      nc = cfg.cols;
    end
    noct = (cfg.octs > OCT_W'(OCT_CAP)) ? OCT_W'(OCT_CAP) : cfg.octs;
  end

  // octave geometry
  logic [DIM_W-1:0] per, per_m1, dy, dx, r0, c0;
  logic [DIM_W-1:0] wx0, wx1, wy0, wy1;
  logic [1:0][DIM_W-1:0] div_num, div_den, div_rem;
  logic div_busy;

  assign per    = DIM_W'(1) << oct_r;
  assign per_m1 = per - DIM_W'(1);
  assign dy     = {1'b0, row_r} & per_m1;
  assign dx     = {1'b0, col_r} & per_m1;
  assign r0     = {1'b0, row_r} & ~per_m1;
  assign c0     = {1'b0, col_r} & ~per_m1;
  assign wx0    = per - dx;
  assign wx1    = dx;
  assign wy0    = per - dy;
  assign wy1    = dy;

  // far corners wrap modulo rows/cols in use: lane 0 row, lane 1 column
  assign div_num[0] = r0 + per;
  assign div_num[1] = c0 + per;
  assign div_den[0] = nr;
  assign div_den[1] = nc;

  obns_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .remainder (div_rem),
    .busy      (div_busy)
  );

  // read coordinates
  logic [DIM_W-1:0] rd_row, rd_col;
  logic             rd_oob, wr_ok;
  logic [AW-1:0]    raddr, waddr;
  logic [SMP_W-1:0] rdata;

  always_comb begin
    case (cmd.rsel)
      RS_C00: begin
        rd_row = r0;
        rd_col = c0;
      end
      RS_C01: begin
        rd_row = r0;
        rd_col = div_rem[1];
      end
      RS_C10: begin
        rd_row = div_rem[0];
        rd_col = c0;
      end
      RS_C11: begin
        rd_row = div_rem[0];
        rd_col = div_rem[1];
      end
      default: begin
        rd_row = {1'b0, row_r};
        rd_col = {1'b0, col_r};
      end
    endcase
  end

  assign rd_oob = (32'(rd_row) >= MAX_ROWS) || (32'(rd_col) >= MAX_COLS);
  assign raddr  = AW'(32'(rd_row) * MAX_COLS + 32'(rd_col));
  assign wr_ok  = (32'(row_r) < MAX_ROWS) && (32'(col_r) < MAX_COLS);
  assign waddr  = AW'(32'(row_r) * MAX_COLS + 32'(col_r));

  obns_ram #(
    .WIDTH (SMP_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (cmd.ram_we && wr_ok),
    .waddr (waddr),
    .wdata (smp_r),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // cells outside the store read as zero
  logic signed [SMP_W-1:0] corner;
  assign corner = rd_oob_r ? '0 : signed'(rdata);

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MAC_W-1:0]   mul_p;

  always_comb begin
    case (cmd.msel)
      MS_CORNER_WX0: begin
        mul_a = MUL_A_W'(corner);
        mul_b = signed'(MUL_B_W'(wx0));
      end
      MS_CORNER_WX1: begin
        mul_a = MUL_A_W'(corner);
        mul_b = signed'(MUL_B_W'(wx1));
      end
      MS_NEAR_WY0: begin
        mul_a = MUL_A_W'(near_r);
        mul_b = signed'(MUL_B_W'(wy0));
      end
      MS_FAR_WY1: begin
        mul_a = MUL_A_W'(far_r);
        mul_b = signed'(MUL_B_W'(wy1));
      end
      MS_MAC_AMP: begin
        mul_a = mac_r[MUL_A_W-1:0];
        mul_b = signed'(MUL_B_W'(amp_r));
      end
      MS_AMP_PERS: begin
        mul_a = signed'(MUL_A_W'(amp_r));
        mul_b = signed'(MUL_B_W'(cfg.pers));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  logic signed [MAC_W-1:0] amp_rnd;
  assign mac_nxt = (cmd.mac_load ? '0 : mac_r) + mul_p;
  assign amp_rnd = mul_p + MAC_W'(32768);
  assign amp_nxt = amp_rnd[16 +: AMP_W];

  // round the product to Q6.14: add half an LSB, floor by 2*o+16
  logic [SH_W-1:0]         sh;
  logic signed [MAC_W-1:0] half, rnd, shifted;
  assign sh      = SH_W'({oct_r, 1'b0}) + SH_W'(16);
  assign half    = signed'(MAC_W'(1) << (sh - SH_W'(1)));
  assign rnd     = mac_r + half;
  assign shifted = rnd >>> sh;
  assign tot_nxt = tot_r + shifted[TOT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      row_r <= in_row;
      col_r <= in_col;
      smp_r <= in_sample;
    end
    if (cmd.rd_en) begin
      rd_oob_r <= rd_oob;
    end
    if (cmd.mac_en) begin
      mac_r <= mac_nxt;
    end
    if (cmd.near_en) begin
      near_r <= mac_r[NEAR_W-1:0];
    end
    if (cmd.far_en) begin
      far_r <= mac_r[NEAR_W-1:0];
    end
    if (cmd.amp_init) begin
      amp_r <= AMP_ONE;
    end else if (cmd.amp_en) begin
      amp_r <= amp_nxt;
    end
    if (cmd.tot_init) begin
      oct_r <= '0;
      tot_r <= TOT_W'(corner);
    end else if (cmd.tot_add) begin
      tot_r <= tot_nxt;
    end
    if (cmd.oct_inc) begin
      oct_r <= oct_r + 1'b1;
    end
    if (cmd.out_load) begin
      if (tot_r > TOT_MAX) begin
        val_r <= VAL_MAX;
        sat_r <= 1'b1;
      end else if (tot_r < TOT_MIN) begin
        val_r <= VAL_MIN;
        sat_r <= 1'b1;
      end else begin
        val_r <= tot_r[VAL_W-1:0];
        sat_r <= 1'b0;
      end
    end
  end

  assign stat.div_busy  = div_busy;
  assign stat.noct_zero = (noct == '0);
  assign stat.last_oct  = (oct_r == noct - 1'b1);

  assign out_value     = val_r;
  assign out_saturated = sat_r;

endmodule

// ===== hdl/obns_ctrl.sv =====
// ----------------------------------------------------------------------------
// obns_ctrl: sequencer of the octave noise smoother
// Steps one item at a time through write, center read and the per-octave
// corner reads and multiply-accumulate; owns the result valid flag.
// ----------------------------------------------------------------------------
module obns_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_opcode,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output obns_pkg::dp_cmd_t   cmd,
  input  obns_pkg::dp_stat_t  stat
);
  import obns_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WR   = 4'd1;
  localparam logic [3:0] S_CA   = 4'd2;
  localparam logic [3:0] S_CD   = 4'd3;
  localparam logic [3:0] S_AMP  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_R00  = 4'd6;
  localparam logic [3:0] S_R01  = 4'd7;
  localparam logic [3:0] S_R10  = 4'd8;
  localparam logic [3:0] S_R11  = 4'd9;
  localparam logic [3:0] S_M11  = 4'd10;
  localparam logic [3:0] S_IY0  = 4'd11;
  localparam logic [3:0] S_IY1  = 4'd12;
  localparam logic [3:0] S_PRD  = 4'd13;
  localparam logic [3:0] S_ACC  = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt    = state_r;
    ovalid_nxt   = ovalid_r && out_stall;
    cmd          = '0;
    cmd.rsel     = RS_CENTER;
    cmd.msel     = MS_CORNER_WX0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = (in_opcode == OP_QUERY) ? S_CA : S_WR;
        end
      end
      S_WR: begin
        cmd.ram_we = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_CA: begin
        cmd.rd_en = 1'b1;
        cmd.rsel  = RS_CENTER;
        state_nxt = S_CD;
      end
      S_CD: begin
        cmd.tot_init = 1'b1;
        cmd.amp_init = 1'b1;
        state_nxt    = stat.noct_zero ? S_FIN : S_AMP;
      end
      S_AMP: begin
        cmd.msel      = MS_AMP_PERS;
        cmd.amp_en    = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_R00;
        end
      end
      S_R00: begin
        cmd.rd_en = 1'b1;
        cmd.rsel  = RS_C00;
        state_nxt = S_R01;
      end
      S_R01: begin
        cmd.rd_en    = 1'b1;
        cmd.rsel     = RS_C01;
        cmd.msel     = MS_CORNER_WX0;
        cmd.mac_en   = 1'b1;
        cmd.mac_load = 1'b1;
        state_nxt    = S_R10;
      end
      S_R10: begin
        cmd.rd_en  = 1'b1;
        cmd.rsel   = RS_C10;
        cmd.msel   = MS_CORNER_WX1;
        cmd.mac_en = 1'b1;
        state_nxt  = S_R11;
      end
      S_R11: begin
        cmd.rd_en    = 1'b1;
        cmd.rsel     = RS_C11;
        cmd.near_en  = 1'b1;
        cmd.msel     = MS_CORNER_WX0;
        cmd.mac_en   = 1'b1;
        cmd.mac_load = 1'b1;
        state_nxt    = S_M11;
      end
      S_M11: begin
        cmd.msel   = MS_CORNER_WX1;
        cmd.mac_en = 1'b1;
        state_nxt  = S_IY0;
      end
      S_IY0: begin
        cmd.far_en   = 1'b1;
        cmd.msel     = MS_NEAR_WY0;
        cmd.mac_en   = 1'b1;
        cmd.mac_load = 1'b1;
        state_nxt    = S_IY1;
      end
      S_IY1: begin
        cmd.msel   = MS_FAR_WY1;
        cmd.mac_en = 1'b1;
        state_nxt  = S_PRD;
      end
      S_PRD: begin
        cmd.msel     = MS_MAC_AMP;
        cmd.mac_en   = 1'b1;
        cmd.mac_load = 1'b1;
        state_nxt    = S_ACC;
      end
      S_ACC: begin
        cmd.tot_add = 1'b1;
        cmd.oct_inc = 1'b1;
        state_nxt   = stat.last_oct ? S_FIN : S_AMP;
      end
      S_FIN: begin
        // output register frees up this cycle or is already empty
        if (!ovalid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

// ===== hdl/octave_bilinear_noise_smoother.sv =====
// ----------------------------------------------------------------------------
// octave_bilinear_noise_smoother: value noise grid with octave smoothing
// Stores a grid of Q2.14 samples; a query returns the cell's sample plus
// the persistence-weighted sum of bilinear octave interpolations, Q6.14.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in_     | sink      | in_valid / in_stall   | opcode, row, col, sample
//  out_    | source    | out_valid / out_stall | value, saturated
//  cfg_    | sink      | cfg_valid / cfg_ready | index, data
//
//  Items: a write or a query holds the input stalled until it is done.
//    Per octave the far-corner wrap runs in the bit-serial remainder
//    unit; the four corners then come one per cycle from the single
//    read port of the grid RAM into one shared multiplier.
//  Reset: synchronous, active low; registers return to 64 x 64, 4 octaves,
//    persistence 0.5. Grid contents are not cleared and must be written
//    before they are read.
//  Stalls: a finished result waits in the output register while the next
//    item is taken and worked on; only the final load waits on out_stall.
//    cfg_ready is always high; the user must write registers only while the
//    block idles, which the block itself does not enforce.
module octave_bilinear_noise_smoother #(
  parameter int MAX_ROWS    = obns_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = obns_pkg::MAX_COLS_DEF,
  parameter int MAX_OCTAVES = obns_pkg::MAX_OCTAVES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_opcode,
  input  logic [obns_pkg::ROW_W-1:0]            in_row,
  input  logic [obns_pkg::COL_W-1:0]            in_col,
  input  logic signed [obns_pkg::SMP_W-1:0]     in_sample,
  // results
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [obns_pkg::VAL_W-1:0]     out_value,
  output logic                                  out_saturated,
  // register writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [obns_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [obns_pkg::CFG_DAT_W-1:0]        cfg_data
);
  import obns_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS: cfg_nxt.rows = cfg_data[DIM_W-1:0];
        CFG_COLS: cfg_nxt.cols = cfg_data[DIM_W-1:0];
        CFG_OCTS: cfg_nxt.octs = cfg_data[OCT_W-1:0];
        CFG_PERS: cfg_nxt.pers = cfg_data[PERS_W-1:0];
        default:  cfg_nxt      = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows <= DIM_W'(64);
      cfg_r.cols <= DIM_W'(64);
      cfg_r.octs <= OCT_W'(4);
      cfg_r.pers <= PERS_W'(32768);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath
  // --------------------------------------------------------------------------
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  obns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  obns_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .cfg           (cfg_r),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_sample     (in_sample),
    .out_value     (out_value),
    .out_saturated (out_saturated)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------

  // a clipped result sits exactly on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_value == VAL_MAX || out_value == VAL_MIN))
    else $error("saturated flag set on an unclipped value");

  // a query keeps the input closed for at least the following cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_opcode == OP_QUERY) |=> in_stall)
    else $error("input reopened right after a query transfer");

  // the remainder unit is running in the cycle after being started
  a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.div_start |=> dp_stat.div_busy)
    else $error("remainder unit did not start");

  // never overwrite a result that is still waiting
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

endmodule
